>>> hw/rtl/cbr_pkg.sv
// ----------------------------------------------------------------------------
// cbr_pkg
// Shared types and constants for the complex basis recombination block.
// ----------------------------------------------------------------------------
package cbr_pkg;

    localparam int MaxIn    = 16;
    localparam int MaxOut   = 16;
    localparam int IdxW     = $clog2(MaxOut);
    localparam int KW       = $clog2(MaxIn);
    localparam int CoefAw   = KW + IdxW;
    localparam int CoefDepth = MaxIn * MaxOut;
    localparam int CntW     = 5;
    localparam int DataW    = 32;
    localparam int AccW     = 64;

    typedef logic [0:0] t_cfg_index;

    localparam t_cfg_index RegInputsInUse  = 1'b0;
    localparam t_cfg_index RegOutputsInUse = 1'b1;

    localparam logic CmdLoad = 1'b0;
    localparam logic CmdData = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } t_state;

endpackage

>>> hw/rtl/complex_basis_recombination.sv
// ----------------------------------------------------------------------------
// complex_basis_recombination
// Per-site complex matrix-vector multiply over a coefficient memory, with
// 64-bit saturating accumulators held in a second memory.
// ----------------------------------------------------------------------------
// A data request walks the output vectors in use, one complex
// multiply-accumulate per cycle through the coefficient memory read port, a
// multiply/round/accumulate pipeline and the accumulator memory. A request
// carrying the last input index then reads out one result per output vector
// through the accumulator read port, waiting whenever the result side
// stalls. The block takes no new request until the current one is fully
// delivered.
module complex_basis_recombination (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  cbr_pkg::t_cfg_index                 i_cfg_index,
    input  logic [cbr_pkg::CntW-1:0]            i_cfg_data,

    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_cmd,
    input  logic [cbr_pkg::IdxW-1:0]            i_out_index,
    input  logic [cbr_pkg::KW-1:0]              i_in_index,
    input  logic signed [cbr_pkg::DataW-1:0]    i_value_re,
    input  logic signed [cbr_pkg::DataW-1:0]    i_value_im,
    input  logic                                i_last_site,

    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [cbr_pkg::IdxW-1:0]            o_result_index,
    output logic signed [cbr_pkg::DataW-1:0]    o_result_re,
    output logic signed [cbr_pkg::DataW-1:0]    o_result_im,
    output logic                                o_last_of_run,
    output logic                                o_block_done
);
    import cbr_pkg::*;

    localparam int TermW = 35;
    localparam int SumW  = AccW + 1;
    localparam logic signed [SumW-1:0]  AccPos = SumW'(65'sh0_4000_0000_0000_0000);
    localparam logic signed [SumW-1:0]  AccNeg = -AccPos;
    localparam logic signed [AccW-1:0]  HalfLsb = AccW'(64'sh2000_0000);
    localparam logic signed [AccW-1:0]  OutMax = AccW'(64'sh7FFF_FFFF);
    localparam logic signed [AccW-1:0]  OutMin = -AccW'(64'sh8000_0000);

    function automatic logic signed [33:0] rnd(input logic signed [AccW-1:0] p);
        logic signed [AccW-1:0] t;
        t = p + HalfLsb;
        return $signed(t[AccW-1:30]);
    endfunction

    function automatic logic [CntW-1:0] clamp_cnt(input logic [CntW-1:0] v,
                                                  input logic [CntW-1:0] hi);
        logic [CntW-1:0] r;
        r = v;
        if (v == '0) r = CntW'(1);
        else if (v > hi) r = hi;
        return r;
    endfunction

    // memories
    logic signed [DataW-1:0] mem_coef_re [CoefDepth];
    logic signed [DataW-1:0] mem_coef_im [CoefDepth];
    logic signed [AccW-1:0]  mem_acc_re  [MaxOut];
    logic signed [AccW-1:0]  mem_acc_im  [MaxOut];
    logic [MaxOut-1:0]       r_acc_vld;

    // configuration
    logic [CntW-1:0] r_cfg_in;
    logic [CntW-1:0] r_cfg_out;
    logic [CntW-1:0] nin_used;
    logic [CntW-1:0] nout_used;
    logic [IdxW-1:0] nout_m1;
    logic [KW-1:0]   nin_m1;

    // control
    t_state          r_state;
    t_state          n_state;
    logic [IdxW-1:0] r_j;
    logic [IdxW-1:0] n_j;
    logic            in_acc;
    logic            data_ok;
    logic            pipe_busy;
    logic            out_load;

    // request hold
    logic [KW-1:0]           r_k;
    logic signed [DataW-1:0] r_vr;
    logic signed [DataW-1:0] r_vi;
    logic                    r_last_site;
    logic                    r_close;

    // pipeline
    logic                    r_p1_valid, r_p2_valid, r_p3_valid;
    logic [IdxW-1:0]         r_p1_j, r_p2_j, r_p3_j;
    logic signed [DataW-1:0] r_cr, r_ci;
    logic signed [AccW-1:0]  r_prr, r_pii, r_pri, r_pir;
    logic signed [TermW-1:0] r_tre, r_tim;
    logic signed [TermW-1:0] n_tre, n_tim;
    logic [IdxW-1:0]         acc_rd_addr;
    logic signed [AccW-1:0]  r_acc_q_re, r_acc_q_im;
    logic                    r_acc_q_vld;
    logic signed [AccW-1:0]  acc_cur_re, acc_cur_im;
    logic signed [SumW-1:0]  sum_re, sum_im;
    logic signed [AccW-1:0]  sat_re, sat_im;

    // output register
    logic                    r_out_valid;
    logic [IdxW-1:0]         r_out_index;
    logic signed [DataW-1:0] r_out_re, r_out_im;
    logic                    r_out_last, r_out_done;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_in  <= CntW'(1);
            r_cfg_out <= CntW'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                RegInputsInUse:  r_cfg_in  <= i_cfg_data;
                RegOutputsInUse: r_cfg_out <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign nin_used  = clamp_cnt(r_cfg_in,  CntW'(MaxIn));
    assign nout_used = clamp_cnt(r_cfg_out, CntW'(MaxOut));
    assign nin_m1    = KW'(nin_used - CntW'(1));
    assign nout_m1   = IdxW'(nout_used - CntW'(1));

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign data_ok    = (CntW'(i_in_index) < nin_used);
    assign pipe_busy  = r_p1_valid || r_p2_valid || r_p3_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_j     <= n_j;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_j      = r_j;
        out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_cmd == CmdData && data_ok) begin
                    n_state = ST_MAC;
                    n_j     = '0;
                end
            end
            ST_MAC: begin
                if (r_j == nout_m1) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_j = r_j + IdxW'(1);
                end
            end
            ST_DRAIN: begin
                if (!pipe_busy) begin
                    n_j     = '0;
                    n_state = r_close ? ST_EMIT_RD : ST_IDLE;
                end
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                out_load = 1'b1;
                n_state  = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                if (!i_out_stall) begin
                    if (r_j == nout_m1) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_j     = r_j + IdxW'(1);
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // hold the data request
    always_ff @(posedge i_clk) begin
        if (in_acc && i_cmd == CmdData) begin
            r_k         <= i_in_index;
            r_vr        <= i_value_re;
            r_vi        <= i_value_im;
            r_last_site <= i_last_site;
            r_close     <= (i_in_index == nin_m1);
        end
    end

    // coefficient memory: write on load, read one entry per issue cycle
    always_ff @(posedge i_clk) begin
        if (in_acc && i_cmd == CmdLoad) begin
            mem_coef_re[{i_in_index, i_out_index}] <= i_value_re;
            mem_coef_im[{i_in_index, i_out_index}] <= i_value_im;
        end
        r_cr <= mem_coef_re[{r_k, r_j}];
        r_ci <= mem_coef_im[{r_k, r_j}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
        end else begin
            r_p1_valid <= (r_state == ST_MAC);
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
        end
    end

    assign n_tre = TermW'(rnd(r_prr)) - TermW'(rnd(r_pii));
    assign n_tim = TermW'(rnd(r_pri)) + TermW'(rnd(r_pir));

    always_ff @(posedge i_clk) begin
        r_p1_j <= r_j;
        r_p2_j <= r_p1_j;
        r_p3_j <= r_p2_j;
        r_prr  <= r_vr * r_cr;
        r_pii  <= r_vi * r_ci;
        r_pri  <= r_vr * r_ci;
        r_pir  <= r_vi * r_cr;
        r_tre  <= n_tre;
        r_tim  <= n_tim;
    end

    // accumulator memory
    assign acc_rd_addr = (r_state == ST_EMIT_RD) ? r_j : r_p2_j;
    assign acc_cur_re  = r_acc_q_vld ? r_acc_q_re : '0;
    assign acc_cur_im  = r_acc_q_vld ? r_acc_q_im : '0;
    assign sum_re      = SumW'(acc_cur_re) + SumW'(r_tre);
    assign sum_im      = SumW'(acc_cur_im) + SumW'(r_tim);

    always_comb begin
        sat_re = AccW'(sum_re);
        if (sum_re > AccPos)      sat_re = AccW'(AccPos);
        else if (sum_re < AccNeg) sat_re = AccW'(AccNeg);
        sat_im = AccW'(sum_im);
        if (sum_im > AccPos)      sat_im = AccW'(AccPos);
        else if (sum_im < AccNeg) sat_im = AccW'(AccNeg);
    end

    always_ff @(posedge i_clk) begin
        r_acc_q_re  <= mem_acc_re[acc_rd_addr];
        r_acc_q_im  <= mem_acc_im[acc_rd_addr];
        r_acc_q_vld <= r_acc_vld[acc_rd_addr];
        if (r_p3_valid) begin
            mem_acc_re[r_p3_j] <= sat_re;
            mem_acc_im[r_p3_j] <= sat_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld <= '0;
        end else if (r_p3_valid) begin
            r_acc_vld[r_p3_j] <= 1'b1;
        end else if (out_load) begin
            r_acc_vld[r_j] <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_index <= r_j;
            r_out_last  <= (r_j == nout_m1);
            r_out_done  <= (r_j == nout_m1) && r_last_site;
            if (acc_cur_re > OutMax)      r_out_re <= DataW'(OutMax);
            else if (acc_cur_re < OutMin) r_out_re <= DataW'(OutMin);
            else                          r_out_re <= DataW'(acc_cur_re);
            if (acc_cur_im > OutMax)      r_out_im <= DataW'(OutMax);
            else if (acc_cur_im < OutMin) r_out_im <= DataW'(OutMin);
            else                          r_out_im <= DataW'(acc_cur_im);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_index = r_out_index;
    assign o_result_re    = r_out_re;
    assign o_result_im    = r_out_im;
    assign o_last_of_run  = r_out_last;
    assign o_block_done   = r_out_done;

endmodule
